FILE: sv/sorted_unique_list_table_defines.svh
// ----------------------------------------------------------------------------
// Sorted unique list table: assertion macros
// Shared concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_LIST_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_LIST_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define SULT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define SULT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SULT_ASSERT(label, clk, rst_n, prop, msg)
`define SULT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: sv/sulst_pkg.sv
// ----------------------------------------------------------------------------
// Sorted unique list table package
// Sizes, codes and shared types of the sorted unique list table.
// ----------------------------------------------------------------------------
package sulst_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int TYPE_W    = 2;
    localparam int STAT_W    = 3;
    localparam int OUT_CNT_W = 7;
    localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INSERT   = 2'd0,
        REQ_DEL_HEAD = 2'd1,
        REQ_DEL_TAIL = 2'd2,
        REQ_DEL_POS  = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADPOS = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_CMP,
        S_INS_CHK,
        S_SHUP_RD,
        S_SHUP_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_GET,
        S_DSH_RD,
        S_DSH_WR,
        S_DONE
    } state_t;

    // Flags from the shared compare unit.
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_t;

endpackage

FILE: sv/sulst_req_if.sv
// ----------------------------------------------------------------------------
// Sorted unique list table request channel
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
interface sulst_req_if
    import sulst_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        req_type;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, req_type, value, position, input ready);
    modport sink   (input valid, req_type, value, position, output ready);
endinterface

FILE: sv/sulst_rsp_if.sv
// ----------------------------------------------------------------------------
// Sorted unique list table response channel
// Valid/ready channel carrying one response transaction.
// ----------------------------------------------------------------------------
interface sulst_rsp_if
    import sulst_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic signed [DATA_W-1:0] removed_value;

    modport source (output valid, status, entry_count, removed_value, input ready);
    modport sink   (input valid, status, entry_count, removed_value, output ready);
endinterface

FILE: sv/sulst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sulst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/sulst_step_unit.sv
// ----------------------------------------------------------------------------
// Sorted unique list table step unit
// Shared signed compare and pointer step used by the sequencer states.
// ----------------------------------------------------------------------------
module sulst_step_unit
    import sulst_pkg::*;
(
    input  logic signed [DATA_W-1:0] entry,
    input  logic signed [DATA_W-1:0] key,
    input  logic [CNT_W-1:0]         ptr,
    output cmp_t                     cmp,
    output logic [CNT_W-1:0]         ptr_inc,
    output logic [CNT_W-1:0]         ptr_dec
);

    always_comb
    begin
        cmp.eq  = (entry == key);
        cmp.gt  = (entry > key);
        ptr_inc = ptr + CNT_W'(1);
        ptr_dec = ptr - CNT_W'(1);
    end

endmodule

FILE: sv/sorted_unique_list_table.sv
// ----------------------------------------------------------------------------
// Sorted unique list table
// Ascending table of unique signed 32-bit values with insert and deletes.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY (64) signed values in ascending order, each
// at most once, in a single-port-read RAM. Every request transaction returns
// exactly one response transaction with a status, the entry count after the
// request and the removed value (zero unless a delete succeeded). Requests are
// handled one at a time by a small sequencer around one shared compare and
// pointer unit; each table access has a read state followed by a state that
// uses the data, because the RAM returns its read data registered. An
// insert scans upward from the bottom until it finds the first entry that is
// not smaller, then moves the entries above the insertion slot up by one and
// writes the new value. A delete reads the victim and moves the entries above
// it down by one. A delete on an empty table or with a bad position goes
// straight to the done state; duplicate and full checks need the scan. The
// request channel is ready whenever the sequencer is idle; a finished response
// waits in an output register so the next request can be taken while the
// previous response is still pending, and the done state only stalls while
// that register still holds an unaccepted response. No clearing pass is
// needed after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "sorted_unique_list_table_defines.svh"

module sorted_unique_list_table
    import sulst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sulst_req_if.sink   req,
    sulst_rsp_if.source rsp
);

    // Sequencer state and working registers.
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]         slot_reg, slot_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    status_t                  res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_removed_reg, res_removed_next;

    // Output register holding a finished response.
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [OUT_CNT_W-1:0]     out_count_reg, out_count_next;
    logic signed [DATA_W-1:0] out_removed_reg, out_removed_next;

    // RAM ports.
    logic                     ram_wr_en;
    logic [CNT_W-1:0]         ram_wr_ptr;
    logic [DATA_W-1:0]        ram_wr_data;
    logic                     ram_rd_en;
    logic [CNT_W-1:0]         ram_rd_ptr;
    logic [DATA_W-1:0]        ram_rd_data;

    // Shared unit.
    cmp_t                     cmp;
    logic [CNT_W-1:0]         ptr_inc;
    logic [CNT_W-1:0]         ptr_dec;

    logic                     req_fire;
    logic                     out_free;
    logic                     pos_ok;

    sulst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_ptr[IDX_W-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_ptr[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    sulst_step_unit u_step (
        .entry   (ram_rd_data),
        .key     (key_reg),
        .ptr     (ptr_reg),
        .cmp     (cmp),
        .ptr_inc (ptr_inc),
        .ptr_dec (ptr_dec)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // A delete position is valid when it lies within 1..count.
    assign pos_ok = (req.position != POS_W'(0))
                 && (CMP_W'(req.position) <= CMP_W'(cnt_reg));

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entry_count   = out_count_reg;
    assign rsp.removed_value = out_removed_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_t'(req.req_type) == REQ_INSERT)
                    begin
                        state_next = S_SRCH;
                    end
                    else if (cnt_reg == CNT_W'(0))
                    begin
                        state_next = S_DONE;
                    end
                    else if (req_t'(req.req_type) == REQ_DEL_POS && !pos_ok)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
            end
            S_SRCH:
            begin
                state_next = (ptr_reg == cnt_reg) ? S_INS_CHK : S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (cmp.eq)
                begin
                    state_next = S_DONE;
                end
                else if (cmp.gt)
                begin
                    state_next = S_INS_CHK;
                end
                else
                begin
                    state_next = S_SRCH;
                end
            end
            S_INS_CHK:
            begin
                state_next = (cnt_reg == CNT_W'(CAPACITY)) ? S_DONE : S_SHUP_RD;
            end
            S_SHUP_RD:
            begin
                state_next = (ptr_reg == slot_reg) ? S_INS_PUT : S_SHUP_WR;
            end
            S_SHUP_WR:
            begin
                state_next = S_SHUP_RD;
            end
            S_INS_PUT:
            begin
                state_next = S_DONE;
            end
            S_DEL_RD:
            begin
                state_next = S_DEL_GET;
            end
            S_DEL_GET:
            begin
                state_next = S_DSH_RD;
            end
            S_DSH_RD:
            begin
                state_next = (ptr_inc == cnt_reg) ? S_DONE : S_DSH_WR;
            end
            S_DSH_WR:
            begin
                state_next = S_DSH_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        cnt_next         = cnt_reg;
        ptr_next         = ptr_reg;
        slot_next        = slot_reg;
        key_next         = key_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        out_removed_next = out_removed_reg;
        ram_wr_en        = 1'b0;
        ram_wr_ptr       = ptr_reg;
        ram_wr_data      = ram_rd_data;
        ram_rd_en        = 1'b0;
        ram_rd_ptr       = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    key_next         = req.value;
                    res_status_next  = ST_OK;
                    res_removed_next = '0;
                    case (req_t'(req.req_type))
                        REQ_INSERT:   ptr_next = '0;
                        REQ_DEL_HEAD: ptr_next = '0;
                        REQ_DEL_TAIL: ptr_next = cnt_reg - CNT_W'(1);
                        REQ_DEL_POS:  ptr_next = CNT_W'(req.position - POS_W'(1));
                        default:      ptr_next = '0;
                    endcase
                    if (req_t'(req.req_type) != REQ_INSERT)
                    begin
                        if (cnt_reg == CNT_W'(0))
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (req_t'(req.req_type) == REQ_DEL_POS && !pos_ok)
                        begin
                            res_status_next = ST_BADPOS;
                        end
                    end
                end
            end
            S_SRCH:
            begin
                if (ptr_reg == cnt_reg)
                begin
                    slot_next = cnt_reg;
                end
                else
                begin
                    ram_rd_en = 1'b1;
                end
            end
            S_SRCH_CMP:
            begin
                if (cmp.eq)
                begin
                    res_status_next = ST_DUP;
                end
                else if (cmp.gt)
                begin
                    slot_next = ptr_reg;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            S_INS_CHK:
            begin
                if (cnt_reg == CNT_W'(CAPACITY))
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    ptr_next = cnt_reg;
                end
            end
            S_SHUP_RD:
            begin
                if (ptr_reg != slot_reg)
                begin
                    ram_rd_en  = 1'b1;
                    ram_rd_ptr = ptr_dec;
                end
            end
            S_SHUP_WR:
            begin
                ram_wr_en = 1'b1;
                ptr_next  = ptr_dec;
            end
            S_INS_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_ptr  = slot_reg;
                ram_wr_data = key_reg;
                cnt_next    = cnt_reg + CNT_W'(1);
            end
            S_DEL_RD:
            begin
                ram_rd_en = 1'b1;
            end
            S_DEL_GET:
            begin
                res_removed_next = ram_rd_data;
            end
            S_DSH_RD:
            begin
                if (ptr_inc == cnt_reg)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    ram_rd_en  = 1'b1;
                    ram_rd_ptr = ptr_inc;
                end
            end
            S_DSH_WR:
            begin
                ram_wr_en = 1'b1;
                ptr_next  = ptr_inc;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_count_next   = OUT_CNT_W'(cnt_reg);
                    out_removed_next = res_removed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        slot_reg        <= slot_next;
        key_reg         <= key_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
        out_removed_reg <= out_removed_next;
    end

    // The count never runs past the table size.
    `SULT_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(CAPACITY), "count above capacity")
    // The count moves by at most one entry per cycle.
    `SULT_ASSERT(a_cnt_step, clk, rst_n,
                 (cnt_reg != $past(cnt_reg)) |->
                     ((cnt_reg == $past(cnt_reg) + CNT_W'(1)) ||
                      (cnt_reg == $past(cnt_reg) - CNT_W'(1))),
                 "count jumped")
    // Table writes stay inside the table and never happen while idle.
    `SULT_ASSERT(a_wr_range, clk, rst_n,
                 ram_wr_en |-> ((ram_wr_ptr < CNT_W'(CAPACITY)) && (state_reg != S_IDLE)),
                 "bad table write")
    // A response with a failure status carries a zero removed value.
    `SULT_ASSERT(a_removed_zero, clk, rst_n,
                 (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.removed_value == '0),
                 "removed value on failure")

endmodule
